[sv/srtf_scheduler_assert.svh]
// Assertion macros used by the scheduler datapath.
`ifndef SRTF_SCHEDULER_ASSERT_SVH
`define SRTF_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge outside reset.
`define SRTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SRTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRTF_ASSERT(label, prop, msg)
`define SRTF_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[sv/srtf_pkg.sv]
// Shared constants, types and state encoding for the SRTF scheduler.
`default_nettype none

package srtf_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int TIME_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_PROCS);
  localparam int PIDX_BITS  = 4;
  localparam int NPROC_BITS = 5;
  localparam int RUN_BITS   = 5;

  localparam logic [TIME_BITS-1:0]  TIME_MAX   = {TIME_BITS{1'b1}};
  localparam logic [NPROC_BITS-1:0] PROC_LIMIT = NPROC_BITS'(MAX_PROCS);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_CALC,
    ST_OUT
  } srtf_state_t;

  typedef struct packed {
    logic load_wr;
    logic scan_start;
    logic scan_rd;
    logic update;
    logic calc;
    logic out_load;
  } srtf_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } srtf_stat_t;

endpackage

`default_nettype wire

[sv/srtf_ifs.sv]
// Channel interfaces for the scheduler: request input, result output, configuration write.
`default_nettype none

interface srtf_in_if;
  import srtf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PIDX_BITS-1:0]  proc_index;
  logic [TIME_BITS-1:0]  arrival_time;
  logic [TIME_BITS-1:0]  burst_time;
  modport source(output valid, action, proc_index, arrival_time, burst_time, input ready);
  modport sink(input valid, action, proc_index, arrival_time, burst_time, output ready);
endinterface

interface srtf_out_if;
  import srtf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] tick_time;
  logic [RUN_BITS-1:0]  running_proc;
  logic                 first_run;
  logic [TIME_BITS-1:0] response_time;
  logic                 finished;
  logic [TIME_BITS-1:0] turnaround_time;
  logic [TIME_BITS-1:0] waiting_time;
  logic                 all_done;
  modport source(output valid, tick_time, running_proc, first_run, response_time, finished,
                 turnaround_time, waiting_time, all_done, input ready);
  modport sink(input valid, tick_time, running_proc, first_run, response_time, finished,
               turnaround_time, waiting_time, all_done, output ready);
endinterface

interface srtf_cfg_if;
  import srtf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [NPROC_BITS-1:0] num_processes;
  modport source(output valid, num_processes, input ready);
  modport sink(input valid, num_processes, output ready);
endinterface

`default_nettype wire

[sv/srtf_ctrl.sv]
// Controller state machine that sequences load and tick requests through the datapath.
`default_nettype none

module srtf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_action,
  output logic                    in_ready,
  input  wire srtf_pkg::srtf_stat_t stat,
  output srtf_pkg::srtf_cmd_t     cmd
);
  import srtf_pkg::*;

  srtf_state_t state;
  srtf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_TICK) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/srtf_dp.sv]
// Datapath: process table, minimum search, per-tick accounting and result register.
`default_nettype none

module srtf_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire srtf_pkg::srtf_cmd_t              cmd,
  output srtf_pkg::srtf_stat_t                  stat,
  input  wire logic                             cfg_we,
  input  wire logic [srtf_pkg::NPROC_BITS-1:0]  cfg_data,
  input  wire logic [srtf_pkg::PIDX_BITS-1:0]   ld_index,
  input  wire logic [srtf_pkg::TIME_BITS-1:0]   ld_arrival,
  input  wire logic [srtf_pkg::TIME_BITS-1:0]   ld_burst,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [srtf_pkg::TIME_BITS-1:0]        out_tick_time,
  output logic [srtf_pkg::RUN_BITS-1:0]         out_running,
  output logic                                  out_first,
  output logic [srtf_pkg::TIME_BITS-1:0]        out_response,
  output logic                                  out_finished,
  output logic [srtf_pkg::TIME_BITS-1:0]        out_turnaround,
  output logic [srtf_pkg::TIME_BITS-1:0]        out_waiting,
  output logic                                  out_all_done
);
  import srtf_pkg::*;

  logic [TIME_BITS-1:0] rem_mem [MAX_PROCS];
  logic [TIME_BITS-1:0] arr_mem [MAX_PROCS];
  logic [TIME_BITS-1:0] bur_mem [MAX_PROCS];

  logic [MAX_PROCS-1:0] run_bits;
  logic [MAX_PROCS-1:0] done_bits;
  logic [MAX_PROCS-1:0] in_use;

  logic [IDX_BITS-1:0]  last_idx;
  logic [IDX_BITS-1:0]  cfg_last;
  logic [TIME_BITS-1:0] cur_time;
  logic [TIME_BITS-1:0] time_inc;

  logic [IDX_BITS-1:0]  scan_idx;
  logic                 rd_valid;
  logic [IDX_BITS-1:0]  rd_idx;
  logic [TIME_BITS-1:0] rd_rem;
  logic [TIME_BITS-1:0] rd_arr;
  logic [TIME_BITS-1:0] rd_bur;
  logic                 rd_take;

  logic                 best_found;
  logic [IDX_BITS-1:0]  best_idx;
  logic [TIME_BITS-1:0] best_rem;
  logic [TIME_BITS-1:0] best_arr;
  logic [TIME_BITS-1:0] best_bur;
  logic [TIME_BITS-1:0] best_rem_dec;

  logic                 ld_ok;
  logic [IDX_BITS-1:0]  ld_addr;

  logic [RUN_BITS-1:0]  res_running;
  logic                 res_first;
  logic [TIME_BITS-1:0] res_resp;
  logic                 res_fin;
  logic [TIME_BITS-1:0] res_turn;
  logic [TIME_BITS-1:0] res_wait;
  logic                 res_all_done;

  assign ld_ok        = {1'b0, ld_index} < PROC_LIMIT;
  assign ld_addr      = IDX_BITS'(ld_index);
  assign time_inc     = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
  assign best_rem_dec = best_rem - 1'b1;
  assign stat.scan_last = (scan_idx == last_idx);
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_last = '0;
    end else if (cfg_data > PROC_LIMIT) begin
      cfg_last = IDX_BITS'(MAX_PROCS - 1);
    end else begin
      cfg_last = IDX_BITS'(cfg_data - 1'b1);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      in_use[i] = (IDX_BITS'(i) <= last_idx);
    end
  end

  // An entry competes when it is unfinished, has work left and has arrived.
  always_comb begin
    rd_take = !done_bits[rd_idx] && (rd_rem != '0) && (rd_arr <= cur_time) &&
              (!best_found || (rd_rem < best_rem) ||
               ((rd_rem == best_rem) && (rd_arr < best_arr)));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && ld_ok) begin
      arr_mem[ld_addr] <= ld_arrival;
      bur_mem[ld_addr] <= ld_burst;
      rem_mem[ld_addr] <= ld_burst;
    end else if (cmd.update && best_found) begin
      rem_mem[best_idx] <= best_rem_dec;
    end
    if (cmd.scan_rd) begin
      rd_rem <= rem_mem[scan_idx];
      rd_arr <= arr_mem[scan_idx];
      rd_bur <= bur_mem[scan_idx];
      rd_idx <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx   <= '0;
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      best_found <= 1'b0;
      run_bits   <= '0;
      done_bits  <= '0;
      cur_time   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_idx <= cfg_last;
      end
      rd_valid <= cmd.scan_rd;
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.scan_start) begin
        best_found <= 1'b0;
      end else if (rd_valid && rd_take) begin
        best_found <= 1'b1;
      end
      if (cmd.load_wr && ld_ok) begin
        run_bits[ld_addr]  <= 1'b0;
        done_bits[ld_addr] <= (ld_burst == '0);
      end else if (cmd.update && best_found) begin
        run_bits[best_idx] <= 1'b1;
        if (best_rem_dec == '0) begin
          done_bits[best_idx] <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        cur_time  <= time_inc;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && rd_take) begin
      best_idx <= rd_idx;
      best_rem <= rd_rem;
      best_arr <= rd_arr;
      best_bur <= rd_bur;
    end
    if (cmd.update) begin
      if (best_found) begin
        res_running <= RUN_BITS'(best_idx) + 1'b1;
        res_first   <= !run_bits[best_idx];
        res_resp    <= run_bits[best_idx] ? '0 : cur_time - best_arr;
        res_fin     <= (best_rem_dec == '0);
        if (best_rem_dec != '0) begin
          res_turn <= '0;
        end else if (time_inc >= best_arr) begin
          res_turn <= time_inc - best_arr;
        end else begin
          res_turn <= '0;
        end
      end else begin
        res_running <= '0;
        res_first   <= 1'b0;
        res_resp    <= '0;
        res_fin     <= 1'b0;
        res_turn    <= '0;
      end
    end
    if (cmd.calc) begin
      res_wait     <= (res_fin && (res_turn >= best_bur)) ? res_turn - best_bur : '0;
      res_all_done <= &(done_bits | ~in_use);
    end
    if (cmd.out_load) begin
      out_tick_time  <= cur_time;
      out_running    <= res_running;
      out_first      <= res_first;
      out_response   <= res_resp;
      out_finished   <= res_fin;
      out_turnaround <= res_turn;
      out_waiting    <= res_wait;
      out_all_done   <= res_all_done;
    end
  end

`include "srtf_scheduler_assert.svh"

  `SRTF_ASSERT(a_pick_unfinished, cmd.update && best_found |-> !done_bits[best_idx], "chosen entry already complete")
  `SRTF_ASSERT(a_no_overwrite, cmd.out_load |-> !out_valid || out_ready, "result register overwritten before taken")
  `SRTF_ASSERT(a_scan_in_range, rd_valid |-> rd_idx <= last_idx, "scan read beyond entries in use")
  `SRTF_ASSERT(a_finish_marks, cmd.update && best_found && best_rem == 1 |=> done_bits[$past(best_idx)], "finished entry not marked complete")
  `SRTF_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && !rd_valid && !best_found, "datapath not idle after reset")

endmodule

`default_nettype wire

[sv/srtf_scheduler.sv]
// Top level of the preemptive shortest-remaining-time-first scheduler.
//
//   Port       Role    Payload
//   sched_in   sink    action, proc_index, arrival_time, burst_time
//   sched_out  source  tick_time, running_proc, first_run, response_time, finished,
//                      turnaround_time, waiting_time, all_done
//   cfg_wr     sink    num_processes
//
// A load request gives no result, and the block stays ready for the next request.
// A tick request passes through the scan of the n entries in use, then DRAIN, UPDATE, CALC and OUT,
// where it waits for a free result register; the next request is taken once the result is loaded:
// the table has one read port, so the minimum search visits one entry per cycle.
// Reset clears the control state and the run and completion flags; no clearing pass is needed.
// A waiting result does not block new requests until the next tick reaches its output cycle.
`default_nettype none

module srtf_scheduler (
  input  wire logic clk,
  input  wire logic rst,
  srtf_in_if.sink   sched_in,
  srtf_out_if.source sched_out,
  srtf_cfg_if.sink  cfg_wr
);
  import srtf_pkg::*;

  srtf_cmd_t  cmd;
  srtf_stat_t stat;
  logic       in_ready;

  assign sched_in.ready = in_ready;
  assign cfg_wr.ready   = 1'b1;

  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sched_in.valid),
    .in_action (sched_in.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srtf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_wr.valid),
    .cfg_data       (cfg_wr.num_processes),
    .ld_index       (sched_in.proc_index),
    .ld_arrival     (sched_in.arrival_time),
    .ld_burst       (sched_in.burst_time),
    .out_valid      (sched_out.valid),
    .out_ready      (sched_out.ready),
    .out_tick_time  (sched_out.tick_time),
    .out_running    (sched_out.running_proc),
    .out_first      (sched_out.first_run),
    .out_response   (sched_out.response_time),
    .out_finished   (sched_out.finished),
    .out_turnaround (sched_out.turnaround_time),
    .out_waiting    (sched_out.waiting_time),
    .out_all_done   (sched_out.all_done)
  );

endmodule

`default_nettype wire

[verif/srtf_scheduler_checker.sv]
// Checker that predicts every scheduler tick result and compares it with the block's output.
`timescale 1ns / 100ps

module srtf_scheduler_checker (
  input  logic clk,
  input  logic rst,
  srtf_in_if   req_ch,
  srtf_out_if  res_ch,
  srtf_cfg_if  cfg_ch,
  input  logic end_of_run,
  output int   pending_ticks,
  output int   mismatch_count
);
  import srtf_pkg::*;

  typedef struct packed {
    logic [TIME_BITS-1:0] tick_time;
    logic [RUN_BITS-1:0]  running_proc;
    logic                 first_run;
    logic [TIME_BITS-1:0] response_time;
    logic                 finished;
    logic [TIME_BITS-1:0] turnaround_time;
    logic [TIME_BITS-1:0] waiting_time;
    logic                 all_done;
  } tick_result_t;

  logic [TIME_BITS-1:0]  work_left [MAX_PROCS];
  logic [TIME_BITS-1:0]  arrive_at [MAX_PROCS];
  logic [TIME_BITS-1:0]  burst_len [MAX_PROCS];
  logic                  started [MAX_PROCS];
  logic                  completed [MAX_PROCS];
  logic [TIME_BITS-1:0]  sched_time;
  logic [NPROC_BITS-1:0] nproc_setting;
  logic                  leftovers_checked;
  tick_result_t          tick_results_due[$];

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  function automatic int entries_in_use();
    if (nproc_setting == '0) return 1;
    if (nproc_setting > PROC_LIMIT) return MAX_PROCS;
    return int'(nproc_setting);
  endfunction

  task automatic load_entry(logic [PIDX_BITS-1:0] idx, logic [TIME_BITS-1:0] arr,
                            logic [TIME_BITS-1:0] bur);
    if (int'(idx) < MAX_PROCS) begin
      arrive_at[idx] = arr;
      burst_len[idx] = bur;
      work_left[idx] = bur;
      started[idx]   = 1'b0;
      completed[idx] = (bur == '0);
    end
  endtask

  task automatic advance_tick(output tick_result_t r);
    int n;
    int pick;
    int i;
    int done;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] fin_t;
    logic [TIME_BITS-1:0] turn;
    n = entries_in_use();
    t = sched_time;
    pick = -1;
    r = '0;
    r.tick_time = t;
    for (i = 0; i < n; i++) begin
      if (!completed[i] && work_left[i] != '0 && arrive_at[i] <= t) begin
        if (pick < 0 || work_left[i] < work_left[pick] ||
            (work_left[i] == work_left[pick] && arrive_at[i] < arrive_at[pick])) begin
          pick = i;
        end
      end
    end
    if (pick >= 0) begin
      r.running_proc = RUN_BITS'(pick + 1);
      if (!started[pick]) begin
        started[pick] = 1'b1;
        r.first_run = 1'b1;
        r.response_time = t - arrive_at[pick];
      end
      work_left[pick] = work_left[pick] - 1'b1;
      if (work_left[pick] == '0) begin
        fin_t = (t < TIME_MAX) ? t + 1'b1 : TIME_MAX;
        turn = (fin_t >= arrive_at[pick]) ? fin_t - arrive_at[pick] : '0;
        completed[pick] = 1'b1;
        r.finished = 1'b1;
        r.turnaround_time = turn;
        r.waiting_time = (turn >= burst_len[pick]) ? turn - burst_len[pick] : '0;
      end
    end
    sched_time = (t < TIME_MAX) ? t + 1'b1 : TIME_MAX;
    done = 0;
    for (i = 0; i < n; i++) begin
      if (completed[i]) done++;
    end
    r.all_done = (done == n);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                             logic [TIME_BITS-1:0] at);
    if (got !== want) begin
      report_mismatch($sformatf("tick at time %0d: %s is %0d, expected %0d",
                                at, name, got, want));
    end
  endtask

  task automatic compare_result();
    tick_result_t want;
    if (tick_results_due.size() == 0) begin
      report_mismatch($sformatf("result for tick time %0d with no tick outstanding",
                                res_ch.tick_time));
      return;
    end
    want = tick_results_due.pop_front();
    check_field("tick_time", 32'(res_ch.tick_time), 32'(want.tick_time), want.tick_time);
    check_field("running_proc", 32'(res_ch.running_proc), 32'(want.running_proc),
                want.tick_time);
    check_field("first_run", 32'(res_ch.first_run), 32'(want.first_run), want.tick_time);
    check_field("response_time", 32'(res_ch.response_time), 32'(want.response_time),
                want.tick_time);
    check_field("finished", 32'(res_ch.finished), 32'(want.finished), want.tick_time);
    check_field("turnaround_time", 32'(res_ch.turnaround_time),
                32'(want.turnaround_time), want.tick_time);
    check_field("waiting_time", 32'(res_ch.waiting_time), 32'(want.waiting_time),
                want.tick_time);
    check_field("all_done", 32'(res_ch.all_done), 32'(want.all_done), want.tick_time);
  endtask

  always @(posedge clk) begin
    tick_result_t predicted;
    if (rst) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        work_left[i] = '0;
        arrive_at[i] = '0;
        burst_len[i] = '0;
        started[i]   = 1'b0;
        completed[i] = 1'b0;
      end
      sched_time = '0;
      nproc_setting = NPROC_BITS'(1);
      leftovers_checked = 1'b0;
      mismatch_count = 0;
      tick_results_due.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        compare_result();
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        nproc_setting = cfg_ch.num_processes;
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.action == ACT_TICK) begin
          advance_tick(predicted);
          tick_results_due.push_back(predicted);
        end else begin
          load_entry(req_ch.proc_index, req_ch.arrival_time, req_ch.burst_time);
        end
      end
      if (end_of_run && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        while (tick_results_due.size() != 0) begin
          predicted = tick_results_due.pop_front();
          report_mismatch($sformatf("tick at time %0d never produced a result",
                                    predicted.tick_time));
        end
      end
    end
    pending_ticks <= tick_results_due.size();
  end

endmodule

[verif/srtf_scheduler_tb.sv]
// Testbench top for the SRTF scheduler: request stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module srtf_scheduler_tb;
  import srtf_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_REQUESTS = 540;

  logic clk = 1'b0;
  logic rst;
  logic end_of_run;
  logic quiet_mode = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done;
  int   pending_ticks;
  int   mismatch_count;
  int   idle_cycles = 0;
  int   ticks_sent = 0;
  int   requests_sent = 0;

  srtf_in_if  in_ch ();
  srtf_out_if out_ch ();
  srtf_cfg_if cfg_ch ();

  srtf_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .sched_in  (in_ch),
    .sched_out (out_ch),
    .cfg_wr    (cfg_ch)
  );

  srtf_scheduler_checker sched_check (
    .clk            (clk),
    .rst            (rst),
    .req_ch         (in_ch),
    .res_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .end_of_run     (end_of_run),
    .pending_ticks  (pending_ticks),
    .mismatch_count (mismatch_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("srtf_scheduler_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    hold_off_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (hold_off_req && !hold_off_done) begin
          hold_off_done = 1'b1;
          gap = HOLD_OFF_CYCLES;
        end else begin
          gap = quiet_mode ? 0 : $urandom_range(0, 9);
        end
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  function automatic logic [TIME_BITS-1:0] sched_now();
    return (ticks_sent >= int'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(ticks_sent);
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_arrival();
    int now_t;
    int sel;
    int lead;
    now_t = int'(sched_now());
    sel = $urandom_range(0, 9);
    if (sel == 0) return TIME_BITS'($urandom_range(0, int'(TIME_MAX)));
    if (sel == 1) return TIME_BITS'(now_t - $urandom_range(0, (now_t < 40) ? now_t : 40));
    lead = now_t + $urandom_range(0, 12);
    return (lead > int'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(lead);
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_burst();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return '0;
    if (sel == 2) return TIME_BITS'($urandom_range(0, int'(TIME_MAX)));
    return TIME_BITS'($urandom_range(1, 8));
  endfunction

  task automatic send_request(logic act, logic [PIDX_BITS-1:0] idx,
                              logic [TIME_BITS-1:0] arr, logic [TIME_BITS-1:0] bur);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.proc_index   <= idx;
    in_ch.arrival_time <= arr;
    in_ch.burst_time   <= bur;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act == ACT_TICK) ticks_sent++;
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(ACT_TICK, PIDX_BITS'($urandom), TIME_BITS'($urandom), TIME_BITS'($urandom));
  endtask

  task automatic write_nproc(logic [NPROC_BITS-1:0] value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.num_processes <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Loads give no result, so a fixed settling time follows the last tick result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int i;
    int phase;
    int n_use;
    int work;
    int tick_total;
    int random_start;
    logic [NPROC_BITS-1:0] setting;
    logic [TIME_BITS-1:0]  arr;
    logic [TIME_BITS-1:0]  bur;

    rst                  <= 1'b1;
    end_of_run           <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_LOAD;
    in_ch.proc_index     <= '0;
    in_ch.arrival_time   <= '0;
    in_ch.burst_time     <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.num_processes <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ties broken by arrival and by index, a late short job preempting, a zero burst,
    // entries that arrive far in the future and the largest field values.
    write_nproc(NPROC_BITS'(MAX_PROCS));
    send_request(ACT_LOAD, 0, 0, 0);
    send_request(ACT_LOAD, 1, 0, 3);
    send_request(ACT_LOAD, 2, 0, 3);
    send_request(ACT_LOAD, 3, 1, 2);
    send_request(ACT_LOAD, 4, 2, 1);
    for (i = 5; i < MAX_PROCS - 1; i++) begin
      send_request(ACT_LOAD, PIDX_BITS'(i), TIME_BITS'(60000 + i),
                   TIME_BITS'($urandom_range(1, int'(TIME_MAX))));
    end
    send_request(ACT_LOAD, PIDX_BITS'(MAX_PROCS - 1), TIME_MAX, TIME_MAX);
    repeat (10) send_tick();

    random_start = requests_sent;
    phase = 0;
    while (requests_sent - random_start < RANDOM_REQUESTS) begin
      settle();
      case (phase)
        0: setting = NPROC_BITS'(31);
        1: setting = NPROC_BITS'(0);
        2: setting = NPROC_BITS'(1);
        3: setting = NPROC_BITS'(MAX_PROCS);
        4: setting = NPROC_BITS'(MAX_PROCS + 1);
        default: setting = NPROC_BITS'($urandom_range(0, 31));
      endcase
      write_nproc(setting);
      n_use = (setting == '0) ? 1 : ((setting > PROC_LIMIT) ? MAX_PROCS : int'(setting));
      quiet_mode = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) == 0);
      work = 0;
      for (i = 0; i < n_use; i++) begin
        arr = pick_arrival();
        bur = pick_burst();
        send_request(ACT_LOAD, PIDX_BITS'(i), arr, bur);
        if (bur < 64) work += int'(bur);
      end
      tick_total = work + $urandom_range(1, 6);
      if (tick_total > 48) tick_total = 48;
      if (phase == 3) begin
        hold_off_req = 1'b1;
        tick_total = 60;
      end
      for (i = 0; i < tick_total; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(ACT_LOAD, PIDX_BITS'($urandom), pick_arrival(), pick_burst());
        end else begin
          send_tick();
        end
      end
      phase++;
    end

    // Reload one entry with a short job, then with a zero burst.
    settle();
    write_nproc(NPROC_BITS'(1));
    quiet_mode = 1'b1;
    send_request(ACT_LOAD, 0, 100, 2);
    repeat (3) send_tick();
    send_request(ACT_LOAD, 0, 5, 0);
    send_tick();
    settle();

    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("srtf_scheduler_tb: PASS");
    end else begin
      $display("srtf_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/srtf_pkg.sv
sv/srtf_ifs.sv
sv/srtf_ctrl.sv
sv/srtf_dp.sv
sv/srtf_scheduler.sv
verif/srtf_scheduler_checker.sv
verif/srtf_scheduler_tb.sv
